// File: rtl/slf_pkg.sv
// Package for the serial line framer.
// Holds the status codes, control states and reset constants.
// No dependencies.
package slf_pkg;

  localparam int unsigned LINE_CAPACITY_DEF = 64;
  localparam logic [7:0]  OUT_LIMIT_RESET   = 8'd64;
  localparam logic [7:0]  CHAR_CR           = 8'h0D;
  localparam logic [7:0]  CHAR_LF           = 8'h0A;

  typedef enum logic [1:0] {
    STAT_NONE = 2'd0,
    STAT_BYTE = 2'd1,
    STAT_ERR  = 2'd2
  } status_e;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } fsm_state_e;

endpackage

// File: rtl/serial_line_framer.sv
// Serial line framer top level: line store memory, fill control and output register.
// Depends on slf_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word: op_i and in_byte_i.
//   A push appends a byte to the line store; CR, LF or a flush ends the line.
//   Output channel (out_valid_o / out_stall_i) carries status_o, line_byte_o, last_o.
//   Each input word gives one result word (status none or error, last set), or a
//   completed line of n bytes as n words of status byte, the n-th with last set.
//   Timing: a single-result word is valid in the cycle after acceptance. The first
//   byte of a line follows the EMIT state, the registered line store read and the
//   output register, then the line streams one byte a cycle while out_stall_i is low.
//   Throughput: one input word a cycle while no line is emitted and the output is
//   not stalled; input is held off while a line is emitted.
//   A new word enters only in a cycle where the output register is empty or its
//   word is taken. If the receiver stalls, the output word holds and input is
//   stalled until the output register frees up.
//   Reset clears the fill count, the overflow flag and the control state and sets
//   out_limit to 64; the line store contents are not cleared. The user must write
//   out_limit through out_limit_we_i only while idle; the block does not enforce it.
module serial_line_framer #(
  parameter int unsigned LINE_CAPACITY = slf_pkg::LINE_CAPACITY_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       out_limit_we_i,
  input  logic [7:0] out_limit_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       op_i,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [7:0] line_byte_o,
  output logic       last_o
);

  localparam int unsigned DEPTH = LINE_CAPACITY - 1;
  localparam int unsigned CNT_W = $clog2(LINE_CAPACITY);
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [7:0] mem [DEPTH];

  slf_pkg::fsm_state_e state_q, state_d;
  logic [CNT_W-1:0]    fill_q, fill_d;
  logic                ovf_q, ovf_d;
  logic [7:0]          limit_q;
  logic [CNT_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic                rdv_q, rdv_d;
  logic [7:0]          rd_data_q;
  logic                rd_last_q, rd_last_d;
  logic                out_valid_q, out_valid_d;
  slf_pkg::status_e    out_status_q, out_status_d;
  logic [7:0]          out_byte_q, out_byte_d;
  logic                out_last_q, out_last_d;

  logic             out_free;
  logic             in_fire;
  logic             is_term;
  logic             start_emit;
  logic             load_rd;
  logic             issue;
  logic             mem_we;
  logic [CNT_W-1:0] rd_ptr_inc;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != slf_pkg::ST_IDLE) || !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign is_term    = (op_i == slf_pkg::OP_FLUSH) || (in_byte_i == slf_pkg::CHAR_CR) ||
                      (in_byte_i == slf_pkg::CHAR_LF);
  assign start_emit = in_fire && (limit_q != 8'd0) && is_term && !ovf_q &&
                      (fill_q != '0) && ({{(8-CNT_W){1'b0}}, fill_q} < limit_q);
  assign load_rd    = (state_q == slf_pkg::ST_EMIT) && rdv_q && out_free;
  assign issue      = (state_q == slf_pkg::ST_EMIT) && (rd_ptr_q != fill_q) &&
                      (!rdv_q || load_rd);
  assign rd_ptr_inc = rd_ptr_q + CNT_W'(1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      slf_pkg::ST_IDLE: begin
        if (start_emit) begin
          state_d = slf_pkg::ST_EMIT;
        end
      end
      slf_pkg::ST_EMIT: begin
        if (load_rd && rd_last_q) begin
          state_d = slf_pkg::ST_IDLE;
        end
      end
      default: state_d = slf_pkg::ST_IDLE;
    endcase
  end

  // datapath and output word
  always_comb begin
    fill_d       = fill_q;
    ovf_d        = ovf_q;
    rd_ptr_d     = rd_ptr_q;
    rdv_d        = rdv_q;
    rd_last_d    = rd_last_q;
    mem_we       = 1'b0;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_byte_d   = out_byte_q;
    out_last_d   = out_last_q;

    case (state_q)
      slf_pkg::ST_IDLE: begin
        if (in_fire) begin
          out_valid_d  = 1'b1;
          out_byte_d   = 8'd0;
          out_last_d   = 1'b1;
          out_status_d = slf_pkg::STAT_NONE;
          rd_ptr_d     = '0;
          rdv_d        = 1'b0;
          if (limit_q == 8'd0) begin
            out_status_d = slf_pkg::STAT_ERR;
          end else if (is_term) begin
            if (ovf_q) begin
              fill_d = '0;
              ovf_d  = 1'b0;
            end else if (fill_q == '0) begin
              out_status_d = slf_pkg::STAT_NONE;
            end else if (!start_emit) begin
              fill_d       = '0;
              out_status_d = slf_pkg::STAT_ERR;
            end else begin
              out_valid_d = 1'b0;
            end
          end else if (ovf_q) begin
            out_status_d = slf_pkg::STAT_ERR;
          end else if (fill_q == FULL_CNT) begin
            ovf_d        = 1'b1;
            fill_d       = '0;
            out_status_d = slf_pkg::STAT_ERR;
          end else begin
            mem_we = 1'b1;
            fill_d = fill_q + CNT_W'(1);
          end
        end
      end
      slf_pkg::ST_EMIT: begin
        if (load_rd) begin
          out_valid_d  = 1'b1;
          out_status_d = slf_pkg::STAT_BYTE;
          out_byte_d   = rd_data_q;
          out_last_d   = rd_last_q;
          rdv_d        = 1'b0;
          if (rd_last_q) begin
            fill_d = '0;
            ovf_d  = 1'b0;
          end
        end
        if (issue) begin
          rdv_d     = 1'b1;
          rd_last_d = (rd_ptr_inc == fill_q);
          rd_ptr_d  = rd_ptr_inc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[fill_q[IDX_W-1:0]] <= in_byte_i;
    end
    if (issue) begin
      rd_data_q <= mem[rd_ptr_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= slf_pkg::ST_IDLE;
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      limit_q     <= slf_pkg::OUT_LIMIT_RESET;
      rd_ptr_q    <= '0;
      rdv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      ovf_q       <= ovf_d;
      rd_ptr_q    <= rd_ptr_d;
      rdv_q       <= rdv_d;
      out_valid_q <= out_valid_d;
      if (out_limit_we_i) begin
        limit_q <= out_limit_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_last_q    <= rd_last_d;
    out_status_q <= out_status_d;
    out_byte_q   <= out_byte_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign line_byte_o = out_byte_q;
  assign last_o      = out_last_q;

`ifndef SYNTHESIS
  a_emit_line_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == slf_pkg::ST_EMIT) |-> (fill_q != '0) && !ovf_q)
    else $error("emitting an empty or overflowed line");

  a_rd_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_ptr_q <= fill_q || state_q == slf_pkg::ST_IDLE)
    else $error("read pointer beyond fill count");

  a_rdv_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdv_q |-> (state_q == slf_pkg::ST_EMIT))
    else $error("read data pending outside emit");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FULL_CNT)
    else $error("fill count exceeds store depth");
`endif

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for serial_line_framer: queued words, random pacing on both channels.
// Predicts line framing, overflow and out_limit errors; depends on slf_pkg and the framer RTL.
module testbench;

  localparam int unsigned CAP = slf_pkg::LINE_CAPACITY_DEF;
  localparam int unsigned STALL_LIMIT = 4000;

  typedef struct packed {
    slf_pkg::op_e op;
    logic [7:0]   data;
  } word_t;

  typedef struct packed {
    slf_pkg::status_e status;
    logic [7:0]       data;
    logic             last;
  } result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         limit_we = 1'b0;
  logic [7:0]   limit_val = 8'd0;
  logic         in_valid = 1'b0;
  logic         in_stall;
  slf_pkg::op_e in_op = slf_pkg::OP_PUSH;
  logic [7:0]   in_data = 8'd0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  logic [1:0]   out_status;
  logic [7:0]   out_data;
  logic         out_last;

  word_t      pending_q[$];
  result_t    framed_q[$];
  logic [7:0] line_mem [CAP-1];
  int unsigned fill_cnt = 0;
  logic       overflowed = 1'b0;
  logic [7:0] limit_shadow = slf_pkg::OUT_LIMIT_RESET;
  logic       in_fire = 1'b0;
  logic       calm = 1'b0;
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;

  serial_line_framer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .out_limit_we_i (limit_we),
    .out_limit_i    (limit_val),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .op_i           (in_op),
    .in_byte_i      (in_data),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (out_status),
    .line_byte_o    (out_data),
    .last_o         (out_last)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void push_result(slf_pkg::status_e st, logic [7:0] d, logic l);
    result_t r;
    r.status = st;
    r.data = d;
    r.last = l;
    framed_q.push_back(r);
  endfunction

  function automatic void frame_word(word_t w);
    int unsigned n;
    if (limit_shadow == 8'd0) begin
      push_result(slf_pkg::STAT_ERR, 8'h00, 1'b1);
    end else if (w.op == slf_pkg::OP_FLUSH || w.data == slf_pkg::CHAR_CR ||
                 w.data == slf_pkg::CHAR_LF) begin
      n = fill_cnt;
      if (overflowed) begin
        push_result(slf_pkg::STAT_NONE, 8'h00, 1'b1);
      end else if (n == 0) begin
        push_result(slf_pkg::STAT_NONE, 8'h00, 1'b1);
      end else if (n >= limit_shadow) begin
        push_result(slf_pkg::STAT_ERR, 8'h00, 1'b1);
      end else begin
        for (int unsigned k = 0; k < n; k++)
          push_result(slf_pkg::STAT_BYTE, line_mem[k], (k + 1 == n));
      end
      fill_cnt = 0;
      overflowed = 1'b0;
    end else if (overflowed) begin
      push_result(slf_pkg::STAT_ERR, 8'h00, 1'b1);
    end else if (fill_cnt >= CAP - 1) begin
      overflowed = 1'b1;
      fill_cnt = 0;
      push_result(slf_pkg::STAT_ERR, 8'h00, 1'b1);
    end else begin
      line_mem[fill_cnt] = w.data;
      fill_cnt++;
      push_result(slf_pkg::STAT_NONE, 8'h00, 1'b1);
    end
  endfunction

  function automatic void note_error(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  always @(negedge clk_i) begin
    word_t w;
    if (rst_ni) begin
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 38);
      if (!in_valid || in_fire) begin
        if (pending_q.size() != 0 && (calm || $urandom_range(99) >= 38)) begin
          w = pending_q.pop_front();
          in_valid <= 1'b1;
          in_op <= w.op;
          in_data <= w.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    result_t exp_w;
    word_t   w;
    if (rst_ni) begin
      in_fire <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (framed_q.size() == 0) begin
          note_error($sformatf("unexpected word: status %0d byte %02h last %0d",
                               out_status, out_data, out_last));
        end else begin
          exp_w = framed_q.pop_front();
          if (out_status !== exp_w.status || out_data !== exp_w.data ||
              out_last !== exp_w.last)
            note_error($sformatf(
              "mismatch: expected status %0d byte %02h last %0d, got %0d %02h %0d",
              exp_w.status, exp_w.data, exp_w.last, out_status, out_data, out_last));
        end
      end
      if (in_valid && !in_stall) begin
        w.op = in_op;
        w.data = in_data;
        frame_word(w);
      end
      if (limit_we) limit_shadow = limit_val;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("testbench: errors");
          $finish;
        end
      end
    end
  end

  task automatic queue_word(slf_pkg::op_e op, logic [7:0] d);
    word_t w;
    w.op = op;
    w.data = d;
    pending_q.push_back(w);
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pending_q.size() != 0 || in_valid || framed_q.size() != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_limit(logic [7:0] v);
    drain();
    @(negedge clk_i);
    limit_we = 1'b1;
    limit_val = v;
    @(negedge clk_i);
    limit_we = 1'b0;
  endtask

  function automatic logic [7:0] data_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == slf_pkg::CHAR_CR || b == slf_pkg::CHAR_LF);
    return b;
  endfunction

  task automatic random_lines(int unsigned count);
    int unsigned queued;
    int unsigned kind;
    int unsigned len;
    queued = 0;
    while (queued < count) begin
      kind = $urandom_range(99);
      if (kind < 10) begin
        queue_word(slf_pkg::op_e'($urandom_range(1)), 8'($urandom_range(255)));
        queued++;
      end else begin
        len = (kind < 18) ? $urandom_range(70, 55) : $urandom_range(12, 0);
        if (len > count - queued - 1) len = count - queued - 1;
        repeat (len) queue_word(slf_pkg::OP_PUSH, data_byte());
        case ($urandom_range(2))
          0: queue_word(slf_pkg::OP_PUSH, slf_pkg::CHAR_CR);
          1: queue_word(slf_pkg::OP_PUSH, slf_pkg::CHAR_LF);
          default: queue_word(slf_pkg::OP_FLUSH, 8'($urandom_range(255)));
        endcase
        queued += len + 1;
      end
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    set_limit(8'd64);
    queue_word(slf_pkg::OP_PUSH, 8'h48);
    queue_word(slf_pkg::OP_PUSH, 8'h00);
    queue_word(slf_pkg::OP_PUSH, 8'hFF);
    queue_word(slf_pkg::OP_PUSH, slf_pkg::CHAR_CR);
    queue_word(slf_pkg::OP_PUSH, slf_pkg::CHAR_LF);
    queue_word(slf_pkg::OP_FLUSH, 8'hA5);
    queue_word(slf_pkg::OP_PUSH, 8'h7F);
    queue_word(slf_pkg::OP_PUSH, 8'h80);
    queue_word(slf_pkg::OP_FLUSH, slf_pkg::CHAR_CR);
    set_limit(8'd1);
    queue_word(slf_pkg::OP_PUSH, 8'h55);
    queue_word(slf_pkg::OP_PUSH, slf_pkg::CHAR_LF);
    queue_word(slf_pkg::OP_FLUSH, 8'h00);
    set_limit(8'd2);
    queue_word(slf_pkg::OP_PUSH, 8'hAA);
    queue_word(slf_pkg::OP_PUSH, slf_pkg::CHAR_CR);
    queue_word(slf_pkg::OP_PUSH, 8'h01);
    queue_word(slf_pkg::OP_PUSH, 8'h02);
    queue_word(slf_pkg::OP_PUSH, slf_pkg::CHAR_CR);
    set_limit(8'd0);
    queue_word(slf_pkg::OP_PUSH, 8'h41);
    queue_word(slf_pkg::OP_PUSH, slf_pkg::CHAR_CR);
    queue_word(slf_pkg::OP_FLUSH, 8'hFF);

    set_limit(8'd255);
    calm = 1'b1;
    random_lines(50);
    drain();
    calm = 1'b0;
    set_limit(8'd64);
    random_lines(45);
    set_limit(8'd0);
    random_lines(20);
    set_limit(8'd1);
    random_lines(35);
    set_limit(8'($urandom_range(62, 3)));
    random_lines(45);
    set_limit(8'd2);
    random_lines(35);
    set_limit(8'd63);
    random_lines(50);
    set_limit(8'd255);
    random_lines(60);
    drain();

    if (errors == 0 && framed_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/slf_pkg.sv
rtl/serial_line_framer.sv
bench/testbench.sv
